### rtl/core/dwd_pkg.sv
package dwd_pkg;

   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 13;
   localparam int WDAY_W    = 3;
   localparam int STATUS_W  = 1;

   localparam int STEP_LIMIT = 1000000;
   localparam int START_YEAR = 1900;
   localparam int STEP_W     = 20;

   localparam int MOD100_W = 7;
   localparam int MOD400_W = 9;

   localparam logic [STEP_W-1:0]   STEP_LAST   = STEP_W'(STEP_LIMIT - 1);
   localparam logic [WDAY_W-1:0]   WDAY_LAST   = WDAY_W'(6);
   localparam logic [WDAY_W-1:0]   WDAY_NONE   = WDAY_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_FOUND = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_MISS  = 1'b1;

   localparam logic [MONTH_W-1:0]  MONTH_JAN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0]  MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0]  MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0]  MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0]  MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0]  MONTH_NOV = MONTH_W'(11);
   localparam logic [MONTH_W-1:0]  MONTH_DEC = MONTH_W'(12);

   // walked date plus running year residues used for the leap rule
   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [MOD100_W-1:0] year_mod100;
      logic [MOD400_W-1:0] year_mod400;
   } date_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } target_type;

   localparam date_type START_DATE = '{
      day:         DAY_W'(1),
      month:       MONTH_JAN,
      year:        YEAR_W'(START_YEAR),
      year_mod100: MOD100_W'(START_YEAR % 100),
      year_mod400: MOD400_W'(START_YEAR % 400)
   };

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAY_W'(30);
         MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
         default:   len = DAY_W'(31);
      endcase
      return len;
   endfunction

endpackage

### rtl/core/dwd_req_if.sv
interface dwd_req_if;
   import dwd_pkg::*;

   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   target_day;
   logic [MONTH_W-1:0] target_month;
   logic [YEAR_W-1:0]  target_year;

   modport source (output valid, output target_day, output target_month,
                   output target_year, input ready);
   modport sink   (input valid, input target_day, input target_month,
                   input target_year, output ready);
endinterface

### rtl/core/dwd_rsp_if.sv
interface dwd_rsp_if;
   import dwd_pkg::*;

   logic                valid;
   logic                ready;
   logic [WDAY_W-1:0]   weekday;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output weekday, output status, input ready);
   modport sink   (input valid, input weekday, input status, output ready);
endinterface

### rtl/core/dwd_day_step.sv
module dwd_day_step (
   input  dwd_pkg::date_type cur_date,
   output dwd_pkg::date_type next_date
);
   import dwd_pkg::*;

   logic             leap;
   logic [DAY_W-1:0] last_day;

   // divisible by 400, or by 4 and not by 100
   assign leap = (cur_date.year_mod400 == '0) ||
                 ((cur_date.year[1:0] == 2'b00) && (cur_date.year_mod100 != '0));

   assign last_day = month_len(cur_date.month, leap);

   always_comb begin
      next_date = cur_date;
      if (cur_date.day == last_day) begin
         next_date.day = DAY_W'(1);
         if (cur_date.month == MONTH_DEC) begin
            next_date.month = MONTH_JAN;
            next_date.year  = cur_date.year + YEAR_W'(1);
            next_date.year_mod100 = (cur_date.year_mod100 == MOD100_W'(99)) ?
                                    '0 : cur_date.year_mod100 + MOD100_W'(1);
            next_date.year_mod400 = (cur_date.year_mod400 == MOD400_W'(399)) ?
                                    '0 : cur_date.year_mod400 + MOD400_W'(1);
         end else begin
            next_date.month = cur_date.month + MONTH_W'(1);
         end
      end else begin
         next_date.day = cur_date.day + DAY_W'(1);
      end
   end

endmodule

### rtl/core/date_weekday_by_day_walk_unit.sv
// Weekday finder that walks the calendar one day per cycle from 1 January
// 1900 (a Monday) until the walked date equals the requested date.
// req_if: target_day, target_month, target_year; a transfer happens when
//   valid and ready are both high. ready is high only while the unit idles.
// rsp_if: weekday (1 Monday .. 7 Sunday) and status (0 found, 1 not found).
//   Invalid dates, years before 1900 and dates 1000000 or more days after
//   the start all return weekday 0, status 1.
// A miss ends once the walked year passes the target year or the step
//   counter reaches its limit. The day stepper is the single unit reused on
//   every cycle of the walk.
// req ready rises together with rsp valid; the unit takes no new request
//   before it has passed its previous result to the output register.
// The result sits in an output register; if the receiver stalls, a finished
//   result waits in the unit until the register frees up, and no new request
//   is taken meanwhile.
// Reset (synchronous, active high) returns the walk to the start date,
//   drops rsp valid and makes the unit idle.
module date_weekday_by_day_walk_unit (
   input logic        clock,
   input logic        reset,
   dwd_req_if.sink    req_if,
   dwd_rsp_if.source  rsp_if
);
   import dwd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   date_type            date_ff, date_in;
   date_type            next_date;
   logic [WDAY_W-1:0]   wday_ff, wday_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   target_type          tgt_ff, tgt_in;
   logic [WDAY_W-1:0]   res_wday_ff, res_wday_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WDAY_W-1:0]   rsp_wday_ff, rsp_wday_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic match, passed, at_limit, out_free;

   dwd_day_step u_day_step (
      .cur_date  (date_ff),
      .next_date (next_date)
   );

   assign match    = (date_ff.day == tgt_ff.day) && (date_ff.month == tgt_ff.month) &&
                     (date_ff.year == tgt_ff.year);
   // once the walk is in a later year the target can no longer come up
   assign passed   = date_ff.year > tgt_ff.year;
   assign at_limit = step_ff == STEP_LAST;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      date_in       = date_ff;
      wday_in       = wday_ff;
      step_in       = step_ff;
      tgt_in        = tgt_ff;
      res_wday_in   = res_wday_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_wday_in   = rsp_wday_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               tgt_in.day   = req_if.target_day;
               tgt_in.month = req_if.target_month;
               tgt_in.year  = req_if.target_year;
               date_in      = START_DATE;
               wday_in      = '0;
               step_in      = '0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            if (match) begin
               res_wday_in   = wday_ff + WDAY_W'(1);
               res_status_in = STATUS_FOUND;
               state_in      = ST_DONE;
            end else if (passed || at_limit) begin
               res_wday_in   = WDAY_NONE;
               res_status_in = STATUS_MISS;
               state_in      = ST_DONE;
            end else begin
               date_in = next_date;
               wday_in = (wday_ff == WDAY_LAST) ? '0 : wday_ff + WDAY_W'(1);
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_wday_in   = res_wday_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         date_ff      <= START_DATE;
         wday_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         date_ff      <= date_in;
         wday_ff      <= wday_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      res_wday_ff   <= res_wday_in;
      res_status_ff <= res_status_in;
      rsp_wday_ff   <= rsp_wday_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_if.ready   = state_ff == ST_IDLE;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.weekday = rsp_wday_ff;
   assign rsp_if.status  = rsp_status_ff;

endmodule

### rtl/core/dwd_checker.sv
module dwd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dwd_pkg::WDAY_W-1:0]    rsp_weekday,
   input logic [dwd_pkg::STATUS_W-1:0]  rsp_status
);
   import dwd_pkg::*;

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weekday) && $stable(rsp_status))
      else $error("stalled result changed");

   // the unit is busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // weekday and status agree
   a_found_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_MISS) == (rsp_weekday == WDAY_NONE)))
      else $error("weekday and status disagree");

   // a new result only comes out of a walk, never while idle
   a_result_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a walk");

endmodule

bind date_weekday_by_day_walk_unit dwd_checker u_dwd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_weekday (rsp_if.weekday),
   .rsp_status  (rsp_if.status)
);

### sim/date_weekday_by_day_walk_unit_test.sv
module date_weekday_by_day_walk_unit_test;
   import dwd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_CYCLES = 3_000_000;
   localparam int unsigned TAIL_CYCLES     = 20;

   typedef struct packed {
      logic [WDAY_W-1:0]   weekday;
      logic [STATUS_W-1:0] status;
   } weekday_result_type;

   logic clock;
   logic reset;

   dwd_req_if req_ch ();
   dwd_rsp_if rsp_ch ();

   date_weekday_by_day_walk_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   weekday_result_type pending_weekdays[$];
   int unsigned        error_count;
   int unsigned        quiet_cycles;
   bit                 sender_gaps_on;
   bit                 sink_stalls_on;
   int unsigned        sink_hold_cycles;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // calendar arithmetic for the expected weekday
   function automatic int unsigned month_days(input logic [MONTH_W-1:0] mo,
                                              input int unsigned yr);
      bit leap;
      leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
      case (mo)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
         MONTH_FEB: return leap ? 29 : 28;
         default: return 31;
      endcase
   endfunction

   function automatic int unsigned leaps_through_year(input int unsigned yr);
      return yr / 4 - yr / 100 + yr / 400;
   endfunction

   function automatic weekday_result_type predict_weekday(input logic [DAY_W-1:0] d,
                                                         input logic [MONTH_W-1:0] m,
                                                         input logic [YEAR_W-1:0] y);
      weekday_result_type res;
      int unsigned        yr;
      int unsigned        dd;
      int unsigned        mm;
      int unsigned        span;
      res.weekday = WDAY_NONE;
      res.status  = STATUS_MISS;
      yr = 32'(y);
      dd = 32'(d);
      mm = 32'(m);
      if (m >= MONTH_JAN && m <= MONTH_DEC && dd >= 1 && yr >= START_YEAR) begin
         if (dd <= month_days(m, yr)) begin
            span = 365 * (yr - START_YEAR) + leaps_through_year(yr - 1)
                 - leaps_through_year(START_YEAR - 1);
            for (int unsigned mo = 1; mo < mm; mo++) begin
               span += month_days(MONTH_W'(mo), yr);
            end
            span += dd - 1;
            if (span < STEP_LIMIT) begin
               res.weekday = WDAY_W'(span % 7 + 1);
               res.status  = STATUS_FOUND;
            end
         end
      end
      return res;
   endfunction

   task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                            input logic [YEAR_W-1:0] y);
      int unsigned gap;
      @(negedge clock);
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.target_day   <= d;
      req_ch.target_month <= m;
      req_ch.target_year  <= y;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_weekdays.push_back(predict_weekday(d, m, y));
   endtask

   task automatic wait_for_results();
      // drop valid so the last transfer is not taken again once the unit idles
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_weekdays.size() != 0) @(posedge clock);
   endtask

   task automatic test_first_week();
      // 1 january 1900 is monday, the next six days run through sunday
      for (int unsigned dd = 1; dd <= 7; dd++) begin
         send_date(DAY_W'(dd), MONTH_JAN, YEAR_W'(START_YEAR));
      end
   endtask

   task automatic test_invalid_dates();
      send_date(DAY_W'(0), MONTH_JAN, YEAR_W'(START_YEAR));
      send_date(DAY_W'(1), MONTH_W'(0), YEAR_W'(START_YEAR));
      send_date(DAY_W'(1), MONTH_W'(13), YEAR_W'(START_YEAR));
      send_date(DAY_W'(31), MONTH_W'(15), YEAR_W'(START_YEAR));
      send_date(DAY_W'(31), MONTH_APR, YEAR_W'(START_YEAR));
      send_date(DAY_W'(30), MONTH_NOV, YEAR_W'(START_YEAR));
      send_date(DAY_W'(31), MONTH_JAN, YEAR_W'(START_YEAR));
      send_date(DAY_W'(31), MONTH_DEC, YEAR_W'(START_YEAR));
   endtask

   task automatic test_leap_rules();
      send_date(DAY_W'(29), MONTH_FEB, YEAR_W'(1900));
      send_date(DAY_W'(28), MONTH_FEB, YEAR_W'(1900));
      send_date(DAY_W'(29), MONTH_FEB, YEAR_W'(1904));
      send_date(DAY_W'(29), MONTH_FEB, YEAR_W'(2000));
      send_date(DAY_W'(29), MONTH_FEB, YEAR_W'(2100));
   endtask

   task automatic test_before_start();
      send_date(DAY_W'(0), MONTH_W'(0), YEAR_W'(0));
      send_date(DAY_W'(31), MONTH_DEC, YEAR_W'(START_YEAR - 1));
   endtask

   task automatic test_step_limit();
      // last day the walk reaches, the first one past it, and all ones
      send_date(DAY_W'(27), MONTH_NOV, YEAR_W'(4637));
      send_date(DAY_W'(28), MONTH_NOV, YEAR_W'(4637));
      send_date(DAY_W'(31), MONTH_W'(15), YEAR_W'(8191));
   endtask

   task automatic test_backpressure();
      sink_hold_cycles = 2500;
      for (int unsigned n = 0; n < 6; n++) begin
         send_date(DAY_W'($urandom_range(1, 31)), MONTH_JAN, YEAR_W'(START_YEAR));
      end
      while (sink_hold_cycles != 0) @(posedge clock);
   endtask

   task automatic test_random_dates(input int unsigned count);
      int unsigned kind;
      int unsigned yr;
      int unsigned mo;
      for (int unsigned n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            yr = START_YEAR + (($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 30));
            mo = $urandom_range(MONTH_JAN, MONTH_DEC);
            send_date(DAY_W'($urandom_range(1, month_days(MONTH_W'(mo), yr))),
                      MONTH_W'(mo), YEAR_W'(yr));
         end else if (kind == 7) begin
            send_date(DAY_W'($urandom_range(0, 31)), MONTH_W'($urandom_range(0, 15)),
                      YEAR_W'($urandom_range(0, START_YEAR - 1)));
         end else begin
            send_date(DAY_W'($urandom_range(0, 31)), MONTH_W'($urandom_range(0, 15)),
                      YEAR_W'(START_YEAR + $urandom_range(0, 3)));
         end
      end
   endtask

   task automatic test_drain_pause();
      send_date(DAY_W'(15), MONTH_W'(6), YEAR_W'(1901));
      send_date(DAY_W'(31), MONTH_W'(14), YEAR_W'(1900));
      wait_for_results();
      send_date(DAY_W'(1), MONTH_JAN, YEAR_W'(START_YEAR));
   endtask

   // result sink: random stalls, plus a long hold when a test asks for one
   initial begin : result_sink
      int unsigned burst;
      int unsigned held;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (sink_hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            held = 0;
            while (held < sink_hold_cycles) begin
               @(negedge clock);
               held++;
            end
            sink_hold_cycles = 0;
         end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      weekday_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_weekdays.size() == 0) begin
            $display("%0t: unexpected result, got weekday %0d status %0d",
                     $time, rsp_ch.weekday, rsp_ch.status);
            error_count++;
         end else begin
            want = pending_weekdays.pop_front();
            if (rsp_ch.weekday !== want.weekday) begin
               $display("%0t: weekday mismatch, expected %0d, got %0d",
                        $time, want.weekday, rsp_ch.weekday);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("date_weekday_by_day_walk_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      error_count         = 0;
      quiet_cycles        = 0;
      sender_gaps_on      = 1'b1;
      sink_stalls_on      = 1'b1;
      sink_hold_cycles    = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.target_day   = '0;
      req_ch.target_month = '0;
      req_ch.target_year  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_first_week();
      test_invalid_dates();
      test_leap_rules();
      test_before_start();
      test_step_limit();
      test_backpressure();
      test_random_dates(41);
      test_drain_pause();

      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      test_random_dates(25);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("date_weekday_by_day_walk_unit regression: pass");
      end else begin
         $display("date_weekday_by_day_walk_unit regression: fail");
      end
      $finish;
   end

endmodule
